### hdl/estm_pkg.sv
`timescale 1ns / 1ps

package estm_pkg;

   // Widths fixed by the stream fields and by the trimmed sum.
   localparam int SPEED_W    = 32;
   localparam int COUNT_W    = 32;
   localparam int GAIN_W     = 32;
   localparam int PERIOD_W   = 8;
   localparam int PROD_W     = 64;
   // Six kept samples of 32 bits each need three more bits of headroom.
   localparam int SUM_W      = 35;
   // The magnitude of that sum never exceeds three times two to the 32nd.
   localparam int MAG_W      = 34;

   // Number of middle samples that survive the trim, which is also the divisor.
   localparam int KEEP_COUNT = 6;

   // Division by six: the magnitude is halved, then multiplied by the
   // reciprocal of three rounded up, scaled by two to the 33rd.
   localparam int                 HALF_W      = MAG_W - 1;
   localparam int                 RECIP_W     = 32;
   localparam logic [RECIP_W-1:0] RECIP_3     = 32'hAAAA_AAAB;
   localparam int                 RECIP_SHIFT = 33;
   localparam int                 LO_W        = 17;
   localparam int                 ACC_W       = HALF_W + RECIP_W;

   // Register indexes on the configuration channel.
   localparam logic CSR_DECIMATION_PERIOD = 1'b0;
   localparam logic CSR_SPEED_GAIN        = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_WRITE,
      ST_SCAN,
      ST_DIV,
      ST_AVG
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### hdl/encoder_speed_trimmed_mean_filter.sv
`timescale 1ns / 1ps

// Encoder speed filter. The req_ channel carries one absolute encoder count per
// tick; every decimation_period ticks the count difference since the last
// sample is scaled by speed_gain (Q16.16), saturated and written into a window
// memory. Once WINDOW_LEN samples are held, the extreme samples are trimmed,
// the middle six are averaged, the mean is blended half and half with the
// previous speed and the new speed leaves on the rsp_ channel, one transfer
// per full window. The csr_ channel writes the period and the gain and is
// always ready.
// A tick that takes no sample leaves the block ready for the next count;
// a sample goes through subtract, multiply, and saturate and write. The
// tick that completes a window adds a rank scan, paced by the single read
// port of the window memory, the divide by six, done as a reciprocal
// multiplication in two halves, and the blend, after which the speed is
// offered on rsp_. No new count is taken while the window is processed.
// Reset clears the tick counter, the previous count, the fill count and the
// speed, and loads period 1 and gain 1.0; the window memory is not cleared.
// A result waits in the output register while the receiver stalls; the
// block keeps taking counts, and stalls only when a further result is ready.

module encoder_speed_trimmed_mean_filter import estm_pkg::*; #(
   parameter int WINDOW_LEN = 10
) (
   input  logic                clock,
   input  logic                reset,
   // Input counts.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [COUNT_W-1:0]  req_tdata,   // [31:0] encoder_count
   // Filtered speed.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SPEED_W-1:0]  rsp_tdata,   // [31:0] filtered_speed
   // Register writes.
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [31:0]         csr_data
);

   localparam int IDX_W      = $clog2(WINDOW_LEN);
   localparam int PW         = $clog2(WINDOW_LEN + 2);
   localparam int KEEP_START = (WINDOW_LEN - KEEP_COUNT) / 2;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LEN - 1);
   localparam logic [IDX_W-1:0] KEEP_LO  = IDX_W'(KEEP_START);
   localparam logic [IDX_W-1:0] KEEP_HI  = IDX_W'(KEEP_START + KEEP_COUNT);
   localparam logic [PW-1:0]    P_KEY    = PW'(1);
   localparam logic [PW-1:0]    P_CMP    = PW'(2);
   localparam logic [PW-1:0]    P_END    = PW'(WINDOW_LEN + 1);

   state_type state_ff, state_in;

   // Configuration.
   logic [PERIOD_W-1:0]        period_ff, period_in;
   logic [GAIN_W-1:0]          gain_ff, gain_in;

   // Tick and sample path.
   logic [PERIOD_W-1:0]        tick_ff, tick_in;
   logic [COUNT_W-1:0]         prev_ff, prev_in;
   logic signed [COUNT_W-1:0]  diff_ff, diff_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [IDX_W-1:0]           fill_ff, fill_in;

   // Rank scan.
   logic [IDX_W-1:0]           outer_ff, outer_in;
   logic [PW-1:0]              step_ff, step_in;
   logic signed [SPEED_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0]           rank_ff, rank_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;

   // Mean, smoothing and output register.
   logic signed [SPEED_W-1:0]  mean_ff, mean_in;
   logic signed [SPEED_W-1:0]  smooth_ff, smooth_in;
   logic [SPEED_W-1:0]         rsp_data_ff, rsp_data_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // Window memory.
   logic signed [SPEED_W-1:0]  win_mem [WINDOW_LEN];
   logic signed [SPEED_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]           rd_addr;
   logic                       mem_we;

   logic                       req_fire;
   logic                       sample_hit;
   logic                       out_free;
   logic                       scan_end;
   logic                       div_start;
   logic                       rsp_load;
   logic signed [SPEED_W-1:0]  sample_sat;
   logic signed [GAIN_W:0]     gain_signed;
   logic [IDX_W-1:0]           cmp_idx;
   logic                       is_lower;
   logic [IDX_W-1:0]           rank_next;
   logic                       keep_it;
   logic signed [SPEED_W:0]    blend_sum;
   logic signed [SPEED_W:0]    blend_adj;
   logic signed [SPEED_W-1:0]  blend;

   div_status_type             div_status;
   logic signed [SPEED_W-1:0]  div_quotient;

   estm_div6 u_div6 (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (sum_ff),
      .div_status   (div_status),
      .div_quotient (div_quotient)
   );

   // Shared conditions and arithmetic.
   always_comb begin
      req_fire    = req_tvalid && req_tready;
      sample_hit  = (tick_ff == period_ff);
      out_free    = !rsp_valid_ff || rsp_tready;
      scan_end    = (state_ff == ST_SCAN) && (step_ff == P_END);
      gain_signed = {1'b0, gain_ff};

      // Saturate the scaled difference to the signed speed range.
      if (prod_ff[PROD_W-1:SPEED_W-1] == '0 || prod_ff[PROD_W-1:SPEED_W-1] == '1) begin
         sample_sat = prod_ff[SPEED_W-1:0];
      end else if (prod_ff[PROD_W-1]) begin
         sample_sat = {1'b1, {(SPEED_W-1){1'b0}}};
      end else begin
         sample_sat = {1'b0, {(SPEED_W-1){1'b1}}};
      end

      // A sample ranks below the key if it is smaller, or equal and earlier in
      // the window; this gives every sample a distinct rank, as a stable sort.
      cmp_idx   = IDX_W'(step_ff - P_CMP);
      is_lower  = (rd_data_ff < key_ff) || ((rd_data_ff == key_ff) && (cmp_idx < outer_ff));
      rank_next = rank_ff + IDX_W'(is_lower);
      keep_it   = (rank_next >= KEEP_LO) && (rank_next < KEEP_HI);

      // Half-and-half blend, halved with truncation toward zero.
      blend_sum = {mean_ff[SPEED_W-1], mean_ff} + {smooth_ff[SPEED_W-1], smooth_ff};
      blend_adj = blend_sum + (SPEED_W + 1)'(blend_sum[SPEED_W]);
      blend     = blend_adj[SPEED_W:1];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && sample_hit) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = (fill_ff == IDX_LAST) ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            if (scan_end && (outer_ff == IDX_LAST)) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      rd_addr    = '0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_MUL: begin
         end
         ST_WRITE: begin
            mem_we = 1'b1;
         end
         ST_SCAN: begin
            // Step zero fetches the key; the following steps fetch each entry.
            if (step_ff == '0) begin
               rd_addr = outer_ff;
            end else if (step_ff != P_END) begin
               rd_addr = IDX_W'(step_ff - P_KEY);
            end
         end
         ST_DIV: begin
            // The divider starts on entry to this state, once the last key
            // has been added to the sum.
            div_start = !div_status.busy && !div_status.done;
         end
         ST_AVG: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // Register next values.
   always_comb begin
      period_in    = period_ff;
      gain_in      = gain_ff;
      tick_in      = tick_ff;
      prev_in      = prev_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      fill_in      = fill_ff;
      outer_in     = outer_ff;
      step_in      = step_ff;
      key_in       = key_ff;
      rank_in      = rank_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      smooth_in    = smooth_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DECIMATION_PERIOD: period_in = csr_data[PERIOD_W-1:0];
            CSR_SPEED_GAIN:        gain_in   = csr_data[GAIN_W-1:0];
            default:               period_in = period_ff;
         endcase
      end

      if (req_fire) begin
         tick_in = sample_hit ? PERIOD_W'(1) : tick_ff + 1'b1;
         if (sample_hit) begin
            diff_in = $signed(req_tdata - prev_ff);
            prev_in = req_tdata;
         end
      end

      if (state_ff == ST_MUL) begin
         prod_in = diff_ff * gain_signed;
      end

      if (state_ff == ST_WRITE) begin
         if (fill_ff == IDX_LAST) begin
            fill_in  = '0;
            outer_in = '0;
            step_in  = '0;
            sum_in   = '0;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end

      if (state_ff == ST_SCAN) begin
         step_in = step_ff + 1'b1;
         if (step_ff == P_KEY) begin
            key_in  = rd_data_ff;
            rank_in = '0;
         end else if (step_ff >= P_CMP) begin
            rank_in = rank_next;
         end
         if (scan_end) begin
            step_in  = '0;
            outer_in = outer_ff + 1'b1;
            if (keep_it) begin
               sum_in = sum_ff + SUM_W'(key_ff);
            end
         end
      end

      if ((state_ff == ST_DIV) && div_status.done) begin
         mean_in = div_quotient;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         smooth_in    = blend;
         rsp_data_in  = blend;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= PERIOD_W'(1);
         gain_ff      <= GAIN_W'(65536);
         tick_ff      <= '0;
         prev_ff      <= '0;
         fill_ff      <= '0;
         smooth_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         gain_ff      <= gain_in;
         tick_ff      <= tick_in;
         prev_ff      <= prev_in;
         fill_ff      <= fill_in;
         smooth_ff    <= smooth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      outer_ff    <= outer_in;
      step_ff     <= step_in;
      key_ff      <= key_in;
      rank_ff     <= rank_in;
      sum_ff      <= sum_in;
      mean_ff     <= mean_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Window memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[fill_ff] <= sample_sat;
      end
      rd_data_ff <= win_mem[rd_addr];
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   // The fill count never points past the last window slot.
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= IDX_LAST)
      else $error("window fill count out of range");

   // Writing the last slot always starts the rank scan from the first entry.
   a_full_scans: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) && (fill_ff == IDX_LAST) |=>
         (state_ff == ST_SCAN) && (outer_ff == '0) && (step_ff == '0))
      else $error("full window did not start a scan");

   // A new result appears only from the blend step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_AVG))
      else $error("result raised outside the blend step");

   // The divider reports completion for a single cycle only.
   a_div_pulse: assert property (@(posedge clock) disable iff (reset)
      div_status.done |=> !div_status.done)
      else $error("divider done held longer than one cycle");

   // No count is taken while the window is being processed; checked here while the divider is busy.
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      div_status.busy |-> !req_tready)
      else $error("count accepted while the divider is busy");
`endif

endmodule

### hdl/estm_div6.sv
`timescale 1ns / 1ps

module estm_div6 import estm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       div_start,
   input  logic signed [SUM_W-1:0]    div_dividend,
   output div_status_type             div_status,
   output logic signed [SPEED_W-1:0]  div_quotient
);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       half_ff, half_in;
   logic [HALF_W-1:0]          mag_ff, mag_in;
   logic [ACC_W-1:0]           acc_ff, acc_in;
   logic                       neg_ff, neg_in;

   logic signed [SUM_W-1:0]    abs_value;
   logic [LO_W-1:0]            mul_a;
   logic [LO_W+RECIP_W-1:0]    part;
   logic [SPEED_W-1:0]         quo_mag;

   // Division by six on the magnitude: halve it, then divide by three through
   // the rounded-up reciprocal, which is exact for every halved magnitude below
   // two to the 33rd. The product is built from the low and the high part of
   // the multiplicand, one after the other, with one small multiplier. The sign goes
   // back on at the end so that the quotient truncates toward zero.
   always_comb begin
      abs_value = div_dividend[SUM_W-1] ? -div_dividend : div_dividend;
      mul_a     = half_ff ? LO_W'(mag_ff[HALF_W-1:LO_W]) : mag_ff[LO_W-1:0];
      part      = mul_a * RECIP_3;

      busy_in = busy_ff;
      done_in = 1'b0;
      half_in = half_ff;
      mag_in  = mag_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;

      if (div_start) begin
         busy_in = 1'b1;
         half_in = 1'b0;
         mag_in  = abs_value[MAG_W-1:1];
         acc_in  = '0;
         neg_in  = div_dividend[SUM_W-1];
      end else if (busy_ff) begin
         if (!half_ff) begin
            acc_in  = ACC_W'(part);
            half_in = 1'b1;
         end else begin
            acc_in  = acc_ff + {part[ACC_W-LO_W-1:0], {LO_W{1'b0}}};
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      half_ff <= half_in;
      mag_ff  <= mag_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
   end

   always_comb begin
      quo_mag         = acc_ff[ACC_W-1:RECIP_SHIFT];
      div_quotient    = neg_ff ? -$signed(quo_mag) : $signed(quo_mag);
      div_status.busy = busy_ff;
      div_status.done = done_ff;
   end

endmodule

### tb/tb_encoder_speed_trimmed_mean_filter.sv
`timescale 1ns / 1ps

// The bench sends encoder counts through the req_ stream and checks each
// filtered speed on the rsp_ stream against its own model of the filter.
// The run is split into phases. Each phase first reprograms the period and
// the gain while the block is idle, then streams counts. The first stretch is
// a short directed sequence of edge values; the rest are random walks of the
// encoder position with occasional large jumps.
module tb_encoder_speed_trimmed_mean_filter;
   import estm_pkg::*;

   localparam int SAMPLE_WINDOW = 10;
   // The middle six samples survive the trim, starting two in from each end.
   localparam int TRIM_START    = (SAMPLE_WINDOW - KEEP_COUNT) / 2;
   localparam int PHASES        = 7;
   // The wait after a drain is long enough for the block to finish a full window,
   // so this covers anything still in flight.
   localparam int SETTLE_CYCLES = 200;
   localparam int REPORT_LIMIT  = 10;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [COUNT_W-1:0]  req_tdata = '0;     // [31:0] encoder_count
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [SPEED_W-1:0]  rsp_tdata;          // [31:0] filtered_speed
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = CSR_DECIMATION_PERIOD;
   logic [31:0]         csr_data = '0;

   encoder_speed_trimmed_mean_filter #(
      .WINDOW_LEN(SAMPLE_WINDOW)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Counts waiting to be sent and speeds waiting to be received.
   logic [COUNT_W-1:0]  count_q[$];
   logic [SPEED_W-1:0]  speed_q[$];

   // Model of the filter: registers and state at their reset values.
   logic [PERIOD_W-1:0] period_cfg  = 8'd1;
   logic [GAIN_W-1:0]   gain_cfg    = 32'd65536;
   logic [PERIOD_W-1:0] tick_count  = '0;
   logic [COUNT_W-1:0]  last_sample = '0;
   logic signed [SPEED_W-1:0] speed_samples [SAMPLE_WINDOW];
   int                  fill_level  = 0;
   logic signed [SPEED_W-1:0] smoothed = '0;

   // Handshake bookkeeping shared between the clocked blocks.
   logic                req_fire = 1'b0;
   logic                idle_on = 1'b0;
   int                  send_gap = 0;
   int                  recv_stall = 0;
   int                  mismatch_count = 0;
   logic [SPEED_W-1:0]  want_speed;
   logic [COUNT_W-1:0]  enc_pos = '0;

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
      if (v < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Advances the filter model by one tick and queues a speed when a window
   // completes.
   task automatic track_count(input logic [COUNT_W-1:0] now);
      logic [COUNT_W-1:0] delta;
      longint             scaled;
      longint             trim_sum;
      logic signed [31:0] key;
      int                 j;
      if (tick_count == period_cfg) begin
         delta = now - last_sample;
         scaled = longint'($signed(delta)) * longint'({32'd0, gain_cfg});
         speed_samples[fill_level] = clamp32(scaled);
         last_sample = now;
         fill_level++;
         if (fill_level == SAMPLE_WINDOW) begin
            // Insertion sort, ascending, then keep the middle six.
            for (int i = 1; i < SAMPLE_WINDOW; i++) begin
               key = speed_samples[i];
               j = i - 1;
               while (j >= 0 && speed_samples[j] > key) begin
                  speed_samples[j + 1] = speed_samples[j];
                  j--;
               end
               speed_samples[j + 1] = key;
            end
            trim_sum = 0;
            for (int k = 0; k < KEEP_COUNT; k++)
               trim_sum += longint'(speed_samples[TRIM_START + k]);
            // Both divisions truncate towards zero.
            smoothed = clamp32((trim_sum / KEEP_COUNT + longint'(smoothed)) / 2);
            speed_q.push_back(smoothed);
            fill_level = 0;
         end
         tick_count = '0;
      end
      tick_count = tick_count + 8'd1;
   endtask

   // Mostly short gaps, now and then a long one; none when idling is off.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 20);
      return $urandom_range(50, 200);
   endfunction

   // The encoder position mostly creeps in small steps, sometimes stands
   // still, and sometimes jumps by a large or a completely random amount.
   function automatic logic [COUNT_W-1:0] next_count(input logic [COUNT_W-1:0] pos);
      int r;
      r = $urandom_range(0, 99);
      if (r < 78) return pos + 32'($urandom_range(0, 4000)) - 32'd2000;
      if (r < 88) return pos;
      if (r < 95) return pos + 32'($urandom_range(0, 1 << 21)) - 32'd1048576;
      return $urandom();
   endfunction

   // Monitor: at each rising edge the accepted count feeds the model first,
   // then any accepted speed is checked against the oldest one expected.
   always @(posedge clock) begin
      req_fire = !reset && req_tvalid && req_tready;
      if (req_fire)
         track_count(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (speed_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected speed transfer 0x%08h", $realtime, rsp_tdata);
         end else begin
            want_speed = speed_q.pop_front();
            if (rsp_tdata !== want_speed) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: filtered_speed expected 0x%08h, got 0x%08h",
                           $realtime, want_speed, rsp_tdata);
            end
         end
      end
   end

   // Driver: both streams change on the falling edge. A count is held until
   // its transfer has happened, then the next one follows after a random gap, which may be none.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         if (!req_tvalid || req_fire) begin
            if (send_gap > 0) begin
               req_tvalid <= 1'b0;
               send_gap--;
            end else if (count_q.size() != 0) begin
               req_tdata  <= count_q.pop_front();
               req_tvalid <= 1'b1;
               send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (recv_stall > 0) begin
            rsp_tready <= 1'b0;
            recv_stall--;
         end else begin
            rsp_tready <= 1'b1;
            recv_stall = pick_gap();
         end
      end
   end

   // Writes both registers back to back; valid stays high between the two.
   task automatic program_filter(input logic [PERIOD_W-1:0] period,
                                 input logic [GAIN_W-1:0] gain);
      csr_index <= CSR_DECIMATION_PERIOD;
      csr_data  <= {24'd0, period};
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      period_cfg = period;
      @(negedge clock);
      csr_index <= CSR_SPEED_GAIN;
      csr_data  <= gain;
      do @(posedge clock); while (!csr_ready);
      gain_cfg = gain;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Holds the sender back until every count has gone and every speed has
   // come, then lets the block finish any sample still in flight. The queues
   // and the valid line are looked at on the rising edge, where the driver
   // leaves them alone.
   task automatic drain();
      while (count_q.size() != 0 || req_tvalid || speed_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   logic [PERIOD_W-1:0] phase_period [PHASES];
   logic [GAIN_W-1:0]   phase_gain [PHASES];
   int                  phase_items [PHASES];

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings (period 1, gain 1.0): the first
      // tick takes no sample, then every tick does. The first window covers
      // both saturation limits, wrap-around in both directions and the
      // largest difference that still fits.
      count_q.push_back(32'h0000_0005);
      count_q.push_back(32'h7FFF_FFFF);
      count_q.push_back(32'h8000_0000);
      count_q.push_back(32'h0000_0000);
      count_q.push_back(32'hFFFF_FFFF);
      count_q.push_back(32'h0000_0001);
      count_q.push_back(32'h0000_8000);
      count_q.push_back(32'h0001_0001);
      count_q.push_back(32'h0000_8000);
      count_q.push_back(32'h0000_8000);
      count_q.push_back(32'h0000_7F00);
      enc_pos = 32'h0000_7F00;
      for (int i = 0; i < 10; i++) begin
         enc_pos = next_count(enc_pos);
         count_q.push_back(enc_pos);
      end
      drain();

      // Phases cover both period extremes, a period lowered below the running
      // counter, and zero, half, unit and full-scale gains.
      phase_period = '{8'd1, 8'd3, 8'd0, 8'd255, 8'd2, 8'd1,
                       8'($urandom_range(1, 8))};
      phase_gain   = '{32'd65536, $urandom(), 32'h0000_8000, 32'hFFFF_FFFF,
                       32'd0, 32'($urandom_range(0, 1 << 20)), $urandom()};
      phase_items  = '{300, 250, 260, 260, 180, 300, 200};

      for (int ph = 0; ph < PHASES; ph++) begin
         program_filter(phase_period[ph], phase_gain[ph]);
         // Two phases run with both streams flat out.
         idle_on = (ph != 0 && ph != 5);
         for (int i = 0; i < phase_items[ph]; i++) begin
            enc_pos = next_count(enc_pos);
            count_q.push_back(enc_pos);
         end
         drain();
      end

      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
